/* rtl/sfp_pkg.sv */
// Shared types, constants and helpers for the swing-foot trajectory point unit.
// Holds the fixed-point formats, transaction structs and pipeline control struct.
// No dependencies.
package sfp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PHASE_W    = FRAC_BITS + 1;
    localparam int POS_W      = FRAC_BITS + 4;
    localparam int WARP_W     = FRAC_BITS + 1;
    localparam int CLR_W      = 16;
    localparam int NUM_STAGES = 6;
    localparam int SAT_W      = 32;

    localparam logic [CLR_W-1:0] CLR_RESET = CLR_W'(6554);

    // 0.8 in phase format
    localparam logic [FRAC_BITS-1:0] C08 = FRAC_BITS'((4 * (2 ** FRAC_BITS) + 2) / 5);

    // floor(v / 10) as (v * DIV10_MUL) >> DIV10_SHIFT, exact for v < 2^(FRAC_BITS+2)
    localparam int DIV10_SHIFT = FRAC_BITS + 6;
    localparam int DIV10_MUL_W = DIV10_SHIFT - 2;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL =
        DIV10_MUL_W'((2 ** DIV10_SHIFT + 9) / 10);

    // sine table generation (elaboration only)
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int SINE_TERMS = 6;
    localparam longint unsigned SINE_DIVS [SINE_TERMS] = '{156, 110, 72, 42, 20, 6};

    localparam logic signed [SAT_W-1:0] POS_MAX = SAT_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [SAT_W-1:0] POS_MIN = SAT_W'(-(2 ** (POS_W - 1)));

    typedef struct packed {
        logic        [PHASE_W-1:0] phase;
        logic signed [POS_W-1:0]   start_x;
        logic signed [POS_W-1:0]   start_y;
        logic signed [POS_W-1:0]   start_z;
        logic signed [POS_W-1:0]   end_x;
        logic signed [POS_W-1:0]   end_y;
        logic signed [POS_W-1:0]   end_z;
    } sfp_cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] foot_x;
        logic signed [POS_W-1:0] foot_y;
        logic signed [POS_W-1:0] foot_z;
    } sfp_point_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } sfp_pipe_ctl_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        priority if (v > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN;
        end
        else
        begin
            r = v;
        end
        return r[POS_W-1:0];
    endfunction

endpackage

/* rtl/sfp_phase_warp.sv */
// Phase warp pipeline, stages 0..2: clamp, quarter-wave sine lookup with
// linear interpolation, 0.8 scaling, and the linear upper-half segment.
// Depends on sfp_pkg.
module sfp_phase_warp #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  sfp_pkg::sfp_pipe_ctl_t        ctl,
    input  logic [sfp_pkg::PHASE_W-1:0]   phase,
    output logic [sfp_pkg::WARP_W-1:0]    warp
);

    localparam int F      = sfp_pkg::FRAC_BITS;
    localparam int ONE_W  = F + 1;
    localparam int DEPTH  = SINE_TABLE_ENTRIES + 1;
    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int POSN_W = F + IDX_W;
    localparam int IP_W   = 2 * F + 3;
    localparam int M_W    = 2 * F + 1;
    localparam int Q_W    = F + 2 + sfp_pkg::DIV10_MUL_W;

    localparam logic [IDX_W:0]                 TWO_N      = (IDX_W + 1)'(2 * SINE_TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]               LAST_IDX   = IDX_W'(SINE_TABLE_ENTRIES);
    localparam logic [sfp_pkg::PHASE_W-1:0]    PHASE_ONE  = sfp_pkg::PHASE_W'(2 ** F);
    localparam logic [sfp_pkg::PHASE_W-1:0]    PHASE_HALF = sfp_pkg::PHASE_W'(2 ** (F - 1));
    localparam logic signed [IP_W-1:0]         IP_HALF    = IP_W'(2 ** (F - 1));
    localparam logic [M_W-1:0]                 M_HALF     = M_W'(2 ** (F - 1));

    function automatic logic [ONE_W-1:0] sine_entry(input int idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (sfp_pkg::HALF_PI_Q30 * 64'(idx)) / SINE_TABLE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < sfp_pkg::SINE_TERMS; k++)
        begin
            t = (64'd1 << 30) - ((x2 * t) >> 30) / sfp_pkg::SINE_DIVS[k];
        end
        s = (x * t) >> 30;
        s = (s + (64'd1 << (29 - F))) >> (30 - F);
        if (s > (64'd1 << F))
        begin
            s = 64'd1 << F;
        end
        return ONE_W'(s);
    endfunction

    logic [ONE_W-1:0] sine_rom [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    // stage 0
    logic [sfp_pkg::PHASE_W-1:0] p_clamp;
    logic [sfp_pkg::PHASE_W-1:0] d_full;
    logic                        upper;
    logic [F-1:0]                p_tab;
    logic [POSN_W:0]             pos_full;
    logic [IDX_W-1:0]            idx;
    logic [IDX_W-1:0]            idx_nxt;
    logic [F+1:0]                v_lin;
    logic [Q_W-1:0]              q_prod;
    logic [F-1:0]                q_lin;
    logic [ONE_W-1:0]            w_up;

    assign p_clamp  = (phase > PHASE_ONE) ? PHASE_ONE : phase;
    assign upper    = p_clamp > PHASE_HALF;
    assign p_tab    = upper ? '0 : p_clamp[F-1:0];
    assign pos_full = (POSN_W + 1)'(p_tab) * (POSN_W + 1)'(TWO_N);
    assign idx      = pos_full[POSN_W-1:F];
    assign idx_nxt  = (idx == LAST_IDX) ? idx : idx + IDX_W'(1);
    assign d_full   = p_clamp - PHASE_HALF;
    assign v_lin    = {d_full[F-1:0], 2'b00} + (F + 2)'(5);
    assign q_prod   = Q_W'(v_lin) * Q_W'(sfp_pkg::DIV10_MUL);
    assign q_lin    = F'(q_prod >> sfp_pkg::DIV10_SHIFT);
    assign w_up     = ONE_W'(sfp_pkg::C08) + ONE_W'(q_lin);

    logic [ONE_W-1:0] t0_reg;
    logic [ONE_W-1:0] t1_reg;
    logic [F-1:0]     fr_reg;
    logic             upper0_reg;
    logic [ONE_W-1:0] wup0_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            t0_reg     <= sine_rom[idx];
            t1_reg     <= sine_rom[idx_nxt];
            fr_reg     <= pos_full[F-1:0];
            upper0_reg <= upper;
            wup0_reg   <= w_up;
        end
    end

    // stage 1: table interpolation
    logic signed [F+1:0]   diff;
    logic signed [IP_W-1:0] ip;
    logic signed [IP_W-1:0] ip_r;
    logic signed [F+2:0]   sv_s;

    assign diff = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
    assign ip   = IP_W'(diff) * IP_W'($signed({1'b0, fr_reg}));
    assign ip_r = (ip + IP_HALF) >>> F;
    assign sv_s = $signed({2'b00, t0_reg}) + ip_r[F+2:0];

    logic [ONE_W-1:0] sv1_reg;
    logic             upper1_reg;
    logic [ONE_W-1:0] wup1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            sv1_reg    <= sv_s[F:0];
            upper1_reg <= upper0_reg;
            wup1_reg   <= wup0_reg;
        end
    end

    // stage 2: scale by 0.8 and pick segment
    logic [M_W-1:0]   m_prod;
    logic [M_W-1:0]   m_rnd;
    logic [ONE_W-1:0] warp_reg;

    assign m_prod = M_W'(sv1_reg) * M_W'(sfp_pkg::C08);
    assign m_rnd  = (m_prod + M_HALF) >> F;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            warp_reg <= upper1_reg ? wup1_reg : m_rnd[ONE_W-1:0];
        end
    end

    assign warp = warp_reg;

endmodule

/* rtl/sfp_geom.sv */
// Position pipeline, stages 0..5: endpoint differences and parabola terms,
// warped-phase products, rounding, saturation and the output register.
// Depends on sfp_pkg.
module sfp_geom (
    input  logic                          clk,
    input  sfp_pkg::sfp_pipe_ctl_t        ctl,
    input  sfp_pkg::sfp_cmd_t             cmd,
    input  logic [sfp_pkg::CLR_W-1:0]     clearance,
    input  logic [sfp_pkg::WARP_W-1:0]    warp,
    output sfp_pkg::sfp_point_t           point
);

    localparam int F     = sfp_pkg::FRAC_BITS;
    localparam int POS_W = sfp_pkg::POS_W;
    localparam int SAT_W = sfp_pkg::SAT_W;
    localparam int D_W   = POS_W + 1;
    localparam int AB_W  = POS_W + 4;
    localparam int RX_W  = POS_W + 2;
    localparam int RA_W  = AB_W + 1;
    localparam int BZ_W  = AB_W + 2;
    localparam int WS_W  = F + 2;
    localparam int PX_W  = D_W + WS_W;
    localparam int PA_W  = AB_W + WS_W;
    localparam int PZ_W  = BZ_W + WS_W;

    localparam logic signed [PX_W-1:0] PX_HALF = PX_W'(2 ** (F - 1));
    localparam logic signed [PA_W-1:0] PA_HALF = PA_W'(2 ** (F - 1));
    localparam logic signed [PZ_W-1:0] PZ_HALF = PZ_W'(2 ** (F - 1));

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sz;
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic signed [AB_W-1:0]  a;
        logic signed [AB_W-1:0]  b;
    } geo_t;

    // stage 0
    logic signed [POS_W-1:0] zmax;
    logic signed [D_W-1:0]   mid;
    logic signed [D_W:0]     d1;
    logic signed [D_W-1:0]   d2;
    geo_t                    geo_next;

    always_comb
    begin
        zmax        = (cmd.end_z > cmd.start_z) ? cmd.end_z : cmd.start_z;
        mid         = D_W'(zmax) + D_W'($signed({1'b0, clearance}));
        d1          = (D_W + 1)'(mid) - (D_W + 1)'(cmd.start_z);
        d2          = D_W'(cmd.end_z) - D_W'(cmd.start_z);
        geo_next.sx = cmd.start_x;
        geo_next.sy = cmd.start_y;
        geo_next.sz = cmd.start_z;
        geo_next.dx = D_W'(cmd.end_x) - D_W'(cmd.start_x);
        geo_next.dy = D_W'(cmd.end_y) - D_W'(cmd.start_y);
        geo_next.a  = (AB_W'(d2) <<< 1) - (AB_W'(d1) <<< 2);
        geo_next.b  = (AB_W'(d1) <<< 2) - AB_W'(d2);
    end

    geo_t geo0_reg;
    geo_t geo1_reg;
    geo_t geo2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            geo0_reg <= geo_next;
        end
        if (ctl.load[1])
        begin
            geo1_reg <= geo0_reg;
        end
        if (ctl.load[2])
        begin
            geo2_reg <= geo1_reg;
        end
    end

    // stage 3: products with the warped phase
    logic signed [WS_W-1:0] w_s3;
    logic signed [PX_W-1:0] px;
    logic signed [PX_W-1:0] py;
    logic signed [PA_W-1:0] pa;
    logic signed [PX_W-1:0] rx;
    logic signed [PX_W-1:0] ry;
    logic signed [PA_W-1:0] ra;

    assign w_s3 = $signed({1'b0, warp});
    assign px   = PX_W'(geo2_reg.dx) * PX_W'(w_s3);
    assign py   = PX_W'(geo2_reg.dy) * PX_W'(w_s3);
    assign pa   = PA_W'(geo2_reg.a) * PA_W'(w_s3);
    assign rx   = (px + PX_HALF) >>> F;
    assign ry   = (py + PX_HALF) >>> F;
    assign ra   = (pa + PA_HALF) >>> F;

    logic signed [POS_W-1:0] sx3_reg;
    logic signed [POS_W-1:0] sy3_reg;
    logic signed [POS_W-1:0] sz3_reg;
    logic signed [AB_W-1:0]  b3_reg;
    logic signed [RX_W-1:0]  rx3_reg;
    logic signed [RX_W-1:0]  ry3_reg;
    logic signed [RA_W-1:0]  ra3_reg;
    logic [sfp_pkg::WARP_W-1:0] w3_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            sx3_reg <= geo2_reg.sx;
            sy3_reg <= geo2_reg.sy;
            sz3_reg <= geo2_reg.sz;
            b3_reg  <= geo2_reg.b;
            rx3_reg <= rx[RX_W-1:0];
            ry3_reg <= ry[RX_W-1:0];
            ra3_reg <= ra[RA_W-1:0];
            w3_reg  <= warp;
        end
    end

    // stage 4: x/y finish, inner parabola term
    logic signed [SAT_W-1:0] fx_sum;
    logic signed [SAT_W-1:0] fy_sum;
    logic signed [BZ_W-1:0]  bz;

    assign fx_sum = SAT_W'(sx3_reg) + SAT_W'(rx3_reg);
    assign fy_sum = SAT_W'(sy3_reg) + SAT_W'(ry3_reg);
    assign bz     = BZ_W'(b3_reg) + BZ_W'(ra3_reg);

    logic signed [POS_W-1:0] fx4_reg;
    logic signed [POS_W-1:0] fy4_reg;
    logic signed [POS_W-1:0] sz4_reg;
    logic signed [BZ_W-1:0]  bz4_reg;
    logic [sfp_pkg::WARP_W-1:0] w4_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            fx4_reg <= sfp_pkg::sat_pos(fx_sum);
            fy4_reg <= sfp_pkg::sat_pos(fy_sum);
            sz4_reg <= sz3_reg;
            bz4_reg <= bz;
            w4_reg  <= w3_reg;
        end
    end

    // stage 5: outer parabola product, output register
    logic signed [PZ_W-1:0]  pz;
    logic signed [PZ_W-1:0]  rz;
    logic signed [SAT_W-1:0] fz_sum;
    sfp_pkg::sfp_point_t     point_reg;

    assign pz     = PZ_W'(bz4_reg) * PZ_W'($signed({1'b0, w4_reg}));
    assign rz     = (pz + PZ_HALF) >>> F;
    assign fz_sum = SAT_W'(sz4_reg) + SAT_W'(rz);

    always_ff @(posedge clk)
    begin
        if (ctl.load[5])
        begin
            point_reg.foot_x <= fx4_reg;
            point_reg.foot_y <= fy4_reg;
            point_reg.foot_z <= sfp_pkg::sat_pos(fz_sum);
        end
    end

    assign point = point_reg;

endmodule

/* rtl/swing_foot_trajectory_point_unit.sv */
// Top level of the swing-foot trajectory point unit: handshake control,
// clearance register, and the phase-warp and position pipelines.
// Depends on sfp_pkg, sfp_phase_warp, sfp_geom.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries a phase and the start
//   and end foot positions; point channel (point_valid / point_stall / point)
//   returns the foot x, y, z for that phase, one point per command, in order.
//   cfg_we / cfg_wdata write the lift clearance; write it only while idle.
//   Throughput: one transaction per cycle while the output is not stalled.
//   The pipeline has six stages; the sine table is a registered dual-read
//   ROM in stage 0.
//   Each stage holds a valid bit and loads when it is empty or its successor
//   moves, so bubbles collapse and cmd_stall rises only when all six stages
//   are full and the output is stalled. A stalled point holds its value.
//   Reset clears all stage valid bits and sets the clearance to 0.1 m.
module swing_foot_trajectory_point_unit #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  sfp_pkg::sfp_cmd_t             cmd,
    output logic                          point_valid,
    input  logic                          point_stall,
    output sfp_pkg::sfp_point_t           point,
    input  logic                          cfg_we,
    input  logic [sfp_pkg::CLR_W-1:0]     cfg_wdata
);

    localparam int NS = sfp_pkg::NUM_STAGES;

    logic [NS-1:0]               stage_valid_reg;
    logic [NS-1:0]               stage_valid_next;
    logic [NS-1:0]               ready;
    logic [sfp_pkg::CLR_W-1:0]   clearance_reg;
    sfp_pkg::sfp_pipe_ctl_t      ctl;
    logic [sfp_pkg::WARP_W-1:0]  warp;

    always_comb
    begin
        ready[NS-1] = !stage_valid_reg[NS-1] || !point_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ready[k] = !stage_valid_reg[k] || ready[k+1];
        end
        stage_valid_next = stage_valid_reg;
        if (ready[0])
        begin
            stage_valid_next[0] = cmd_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (ready[k])
            begin
                stage_valid_next[k] = stage_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            clearance_reg   <= sfp_pkg::CLR_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_we)
            begin
                clearance_reg <= cfg_wdata;
            end
        end
    end

    assign ctl.load    = ready;
    assign cmd_stall   = !ready[0];
    assign point_valid = stage_valid_reg[NS-1];

    sfp_phase_warp #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_warp (
        .clk   (clk),
        .ctl   (ctl),
        .phase (cmd.phase),
        .warp  (warp)
    );

    sfp_geom u_geom (
        .clk       (clk),
        .ctl       (ctl),
        .cmd       (cmd),
        .clearance (clearance_reg),
        .warp      (warp),
        .point     (point)
    );

    a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> stage_valid_reg[0])
        else $error("accepted transaction missing from stage 0");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(&stage_valid_reg) |-> !cmd_stall)
        else $error("input stalled with an empty pipeline stage");

    a_out_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(stage_valid_reg[NS-1]))
        else $error("stalled output stage dropped its transaction");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> clearance_reg == $past(cfg_wdata))
        else $error("clearance register write lost");

endmodule

/* dv/swing_foot_trajectory_point_unit_tb.sv */
// Self-checking testbench for swing_foot_trajectory_point_unit: directed and random
// commands with random stalls, each point checked against a bit-exact predictor.
// Depends on sfp_pkg and the unit's RTL.
module swing_foot_trajectory_point_unit_tb;

    localparam int HALF_PERIOD  = 5;
    localparam int SINE_ENTRIES = 256;
    localparam int Q_BITS       = 16;
    localparam longint Q_ONE    = 64'sd1 << Q_BITS;
    localparam longint Q_HALF   = Q_ONE / 2;
    localparam longint Q08      = (4 * Q_ONE + 2) / 5;
    localparam longint POS_HI   = (64'sd1 << (sfp_pkg::POS_W - 1)) - 1;
    localparam longint POS_LO   = -(64'sd1 << (sfp_pkg::POS_W - 1));
    localparam int CLEARANCE_AT_RESET = 6554;
    localparam int PIPE_LATENCY = 6;
    localparam int HOLD_CYCLES  = 50;
    localparam int PHASE_COUNT  = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int CYCLE_LIMIT  = 500000;

    class trajectory_scoreboard;
        sfp_pkg::sfp_point_t pending_points[$];
        int lift_clearance;
        int mismatches;

        function new();
            lift_clearance = CLEARANCE_AT_RESET;
            mismatches = 0;
        endfunction

        function longint round_q(longint v);
            return (v + Q_HALF) >>> Q_BITS;
        endfunction

        function longint quarter_sine(longint unsigned i);
            longint unsigned x, x2, t, s;
            longint unsigned coeff [6];
            coeff = '{156, 110, 72, 42, 20, 6};
            if (i > SINE_ENTRIES)
            begin
                i = SINE_ENTRIES;
            end
            x = (64'd1686629713 * i) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t = 64'd1 << 30;
            for (int k = 0; k < 6; k++)
            begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / coeff[k];
            end
            s = (x * t) >> 30;
            s = (s + (64'd1 << (29 - Q_BITS))) >> (30 - Q_BITS);
            if (s > Q_ONE)
            begin
                s = Q_ONE;
            end
            return longint'(s);
        endfunction

        function longint warped_phase(longint p);
            longint spot, idx, frac, lo, hi, sv;
            if (p <= Q_HALF)
            begin
                spot = 2 * p * SINE_ENTRIES;
                idx = spot >>> Q_BITS;
                frac = spot & (Q_ONE - 1);
                lo = quarter_sine(idx);
                hi = quarter_sine(idx + 1);
                sv = lo + round_q((hi - lo) * frac);
                return round_q(sv * Q08);
            end
            return Q08 + (4 * (p - Q_HALF) + 5) / 10;
        endfunction

        function logic signed [sfp_pkg::POS_W-1:0] clamp_pos(longint v);
            if (v > POS_HI)
            begin
                v = POS_HI;
            end
            else if (v < POS_LO)
            begin
                v = POS_LO;
            end
            return v[sfp_pkg::POS_W-1:0];
        endfunction

        function sfp_pkg::sfp_point_t predict_point(sfp_pkg::sfp_cmd_t c);
            longint p, sx, sy, sz, ex, ey, ez, w, mid, d1, d2, a, b;
            sfp_pkg::sfp_point_t r;
            p = longint'(c.phase);
            if (p > Q_ONE)
            begin
                p = Q_ONE;
            end
            sx = longint'(c.start_x);
            sy = longint'(c.start_y);
            sz = longint'(c.start_z);
            ex = longint'(c.end_x);
            ey = longint'(c.end_y);
            ez = longint'(c.end_z);
            w = warped_phase(p);
            r.foot_x = clamp_pos(sx + round_q(w * (ex - sx)));
            r.foot_y = clamp_pos(sy + round_q(w * (ey - sy)));
            mid = ((ez > sz) ? ez : sz) + longint'(lift_clearance);
            d1 = mid - sz;
            d2 = ez - sz;
            a = 2 * d2 - 4 * d1;
            b = 4 * d1 - d2;
            r.foot_z = clamp_pos(sz + round_q(w * (b + round_q(a * w))));
            return r;
        endfunction

        function void note_command(sfp_pkg::sfp_cmd_t c);
            pending_points.insert(pending_points.size(), predict_point(c));
        endfunction

        function void compare_field(string name, logic signed [sfp_pkg::POS_W-1:0] want,
                                    logic signed [sfp_pkg::POS_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_point(sfp_pkg::sfp_point_t got);
            sfp_pkg::sfp_point_t want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d",
                         $time, got.foot_x, got.foot_y, got.foot_z);
                return;
            end
            want = pending_points.pop_front();
            compare_field("foot_x", want.foot_x, got.foot_x);
            compare_field("foot_y", want.foot_y, got.foot_y);
            compare_field("foot_z", want.foot_z, got.foot_z);
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    sfp_pkg::sfp_cmd_t cmd = '0;
    logic point_valid;
    logic point_stall = 1'b0;
    sfp_pkg::sfp_point_t point;
    logic cfg_we = 1'b0;
    logic [sfp_pkg::CLR_W-1:0] cfg_wdata = '0;

    trajectory_scoreboard sb = new();
    bit hold_request = 1'b0;
    bit stall_random = 1'b0;
    int cycle_count = 0;

    logic signed [sfp_pkg::POS_W-1:0] swing_start [3];
    logic signed [sfp_pkg::POS_W-1:0] swing_end [3];
    int swing_left = 0;

    swing_foot_trajectory_point_unit #(
        .SINE_TABLE_ENTRIES(SINE_ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point(point),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            sb.note_command(cmd);
        end
        if (rst_n && point_valid && !point_stall)
        begin
            sb.check_point(point);
        end
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, or one long hold-off on request
    always
    begin : receiver
        int n;
        @(negedge clk);
        if (hold_request)
        begin
            point_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clk);
            hold_request = 1'b0;
        end
        else if (stall_random)
        begin
            n = rand_gap();
            point_stall <= (n != 0);
            if (n > 1)
            begin
                repeat (n - 1) @(negedge clk);
            end
        end
        else
        begin
            point_stall <= 1'b0;
        end
    end

    function automatic logic signed [sfp_pkg::POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return sfp_pkg::POS_W'($urandom_range(0, 131072) - 65536);
        end
        if (r < 90)
        begin
            return sfp_pkg::POS_W'($urandom);
        end
        return r[0] ? POS_HI[sfp_pkg::POS_W-1:0] : POS_LO[sfp_pkg::POS_W-1:0];
    endfunction

    function automatic logic [sfp_pkg::PHASE_W-1:0] rand_phase();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return sfp_pkg::PHASE_W'($urandom_range(0, Q_ONE));
        end
        if (r < 90)
        begin
            unique case ($urandom_range(0, 2))
                0: return sfp_pkg::PHASE_W'($urandom_range(0, 4));
                1: return sfp_pkg::PHASE_W'($urandom_range(Q_HALF - 3, Q_HALF + 3));
                default: return sfp_pkg::PHASE_W'($urandom_range(Q_ONE - 4, Q_ONE));
            endcase
        end
        return sfp_pkg::PHASE_W'($urandom);
    endfunction

    // one swing keeps its endpoints for a few commands
    function automatic sfp_pkg::sfp_cmd_t next_command();
        sfp_pkg::sfp_cmd_t c;
        if (swing_left == 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                swing_start[k] = rand_pos();
                swing_end[k] = rand_pos();
            end
            swing_left = $urandom_range(1, 12);
        end
        swing_left--;
        c.phase = rand_phase();
        c.start_x = swing_start[0];
        c.start_y = swing_start[1];
        c.start_z = swing_start[2];
        c.end_x = swing_end[0];
        c.end_y = swing_end[1];
        c.end_z = swing_end[2];
        return c;
    endfunction

    function automatic sfp_pkg::sfp_cmd_t make_cmd(longint p, longint sx, longint sy,
                                                   longint sz, longint ex, longint ey,
                                                   longint ez);
        sfp_pkg::sfp_cmd_t c;
        c.phase = sfp_pkg::PHASE_W'(p);
        c.start_x = sfp_pkg::POS_W'(sx);
        c.start_y = sfp_pkg::POS_W'(sy);
        c.start_z = sfp_pkg::POS_W'(sz);
        c.end_x = sfp_pkg::POS_W'(ex);
        c.end_y = sfp_pkg::POS_W'(ey);
        c.end_z = sfp_pkg::POS_W'(ez);
        return c;
    endfunction

    task automatic send_command(input sfp_pkg::sfp_cmd_t c, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            if (gap > 1)
            begin
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_points();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_clearance(input int value);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= sfp_pkg::CLR_W'(value);
        @(posedge clk);
        sb.lift_clearance = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int clearance;
        bit sender_idle;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_command(make_cmd(0, 1000, -2000, 0, 30000, 40000, 5000), 0);
        send_command(make_cmd(Q_ONE, POS_LO, POS_HI, 0, POS_HI, POS_LO, 0), 0);
        send_command(make_cmd(Q_HALF, POS_LO, POS_HI, POS_HI, POS_HI, POS_LO, POS_HI), 0);
        send_command(make_cmd(Q_HALF + 1, POS_HI, POS_HI, POS_HI, POS_HI, POS_HI, POS_HI), 0);
        send_command(make_cmd(Q_HALF - 1, POS_LO, POS_LO, POS_LO, POS_LO, POS_LO, POS_LO), 0);
        send_command(make_cmd(Q_ONE + 1, -5000, 7000, 100, 9000, -3000, 200), 0);
        send_command(make_cmd((64'sd1 << sfp_pkg::PHASE_W) - 1, POS_LO, 0, POS_HI, POS_HI, 0,
                              POS_LO), 0);
        send_command(make_cmd(1, POS_HI, POS_LO, POS_LO, POS_LO, POS_HI, POS_HI), 0);
        send_command(make_cmd(128, -65536, 65536, -65536, 65536, -65536, 65536), 0);
        send_command(make_cmd(255, 0, 0, 0, 0, 0, 0), 0);
        send_command(make_cmd(256, -1, -1, -1, 1, 1, 1), 0);
        send_command(make_cmd(8600, 0, 0, POS_HI - 100, 0, 0, POS_HI - 200), 0);
        send_command(make_cmd(Q_ONE - 1, 123456, -234567, 345678, -456789, 12345, -54321), 0);
        send_command(make_cmd(40000, POS_HI, POS_HI, POS_LO, POS_LO, POS_LO, POS_LO), 0);
        send_command(make_cmd(20000, 0, 0, POS_LO, 0, 0, POS_HI), 0);
        send_command(make_cmd(Q_ONE, 0, 0, POS_HI, 0, 0, POS_LO), 0);
        drain_points();

        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            unique case (phase_no)
                0: clearance = 0;
                1: clearance = 65535;
                2: clearance = 1;
                3: clearance = 32768;
                5: clearance = CLEARANCE_AT_RESET;
                7: clearance = 65535;
                default: clearance = $urandom_range(0, 65535);
            endcase
            write_clearance(clearance);
            sender_idle = (phase_no != 0) && (phase_no != 2) && (phase_no != 6);
            stall_random = (phase_no != 0) && (phase_no != 5);
            if (phase_no == 2)
            begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (sender_idle && $urandom_range(0, 99) == 0)
                begin
                    drain_points();
                end
                send_command(next_command(), sender_idle ? rand_gap() : 0);
            end
            drain_points();
        end

        stall_random = 1'b0;
        repeat (PIPE_LATENCY * 3) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
